FILE: rtl/at_response_line_matcher_core_assert.svh
// Assertion macros for the AT response line matcher core.
// Used by the modules that carry concurrent checks; they expect clk and rst_n in scope.
`ifndef AT_RESPONSE_LINE_MATCHER_CORE_ASSERT_SVH
`define AT_RESPONSE_LINE_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset.
`define ATRLM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("atrlm: invariant violated");
// Consequent must hold in the cycle after the antecedent.
`define ATRLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atrlm: next-cycle check failed");
`else
`define ATRLM_ASSERT_ALWAYS(label, expr)
`define ATRLM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/atrlm_pkg.sv
// Shared types, constants and pattern tables for the AT response line matcher.
// No dependencies; the other files, the assertion header apart, refer to this package by scoped names.
`timescale 1ns / 1ps

package atrlm_pkg;

    // Default receive buffer size in bytes.
    localparam int BUFFER_BYTES_DEFAULT = 1024;

    // Pattern table geometry.
    localparam int PAT_COUNT = 4;
    localparam int PAT_SLOTS = 16;

    // Line length saturates here; no pattern is that long.
    localparam logic [3:0] LINE_SAT = 4'hF;

    localparam logic [7:0] NEWLINE = 8'h0A;
    localparam logic [7:0] CR      = 8'h0D;

    // Kind of an input word.
    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_REARM = 1'b1
    } kind_t;

    // Acknowledgement codes.
    typedef enum logic [1:0] {
        ACK_OK    = 2'd0,
        ACK_ERROR = 2'd1,
        ACK_BUSY  = 2'd2,
        ACK_READY = 2'd3
    } ack_code_t;

    // Acknowledgement texts, CR LF included, padded with zeros.
    localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_SLOTS] = '{
        '{"O", "K", CR, NEWLINE, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "R", "R", "O", "R", CR, NEWLINE, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "u", "s", "y", " ", "p", ".", ".",
          ".", CR, NEWLINE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "a", "d", "y", CR, NEWLINE, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Length of each acknowledgement text.
    localparam logic [3:0] PAT_LEN [PAT_COUNT] = '{4'd4, 4'd7, 4'd11, 4'd7};

    // One input word as held in the input register.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
    } item_t;

    // Result of one word, passed to the output register.
    typedef struct packed {
        logic      valid;
        ack_code_t code;
    } result_t;

endpackage

FILE: rtl/atrlm_in_stage.sv
// Input register of the AT response line matcher: holds one accepted word.
// Depends on atrlm_pkg for the item type.
`timescale 1ns / 1ps

module atrlm_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            kind,
    input  logic [7:0]      rx_byte,
    input  logic            take,
    output logic            item_valid,
    output atrlm_pkg::item_t item
);

    logic             item_valid_reg;
    logic             item_valid_next;
    atrlm_pkg::item_t item_reg;
    logic             load;

    // The register frees up when its word is taken by the match stage.
    assign in_ready = !item_valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    // Control bit is reset; the payload is only loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.kind    <= atrlm_pkg::kind_t'(kind);
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/atrlm_line_match.sv
// Line state and parallel pattern compare of the AT response line matcher.
// Depends on atrlm_pkg and the assertion macros in at_response_line_matcher_core_assert.svh.
`timescale 1ns / 1ps
`include "at_response_line_matcher_core_assert.svh"

module atrlm_line_match #(
    parameter int BUFFER_BYTES = atrlm_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  atrlm_pkg::item_t   item,
    input  logic               res_ready,
    output logic               take,
    output atrlm_pkg::result_t res
);

    localparam int              FILL_W     = $clog2(BUFFER_BYTES);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(BUFFER_BYTES - 1);

    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    logic [3:0]        line_length_reg;
    logic [3:0]        line_length_next;
    logic [3:0]        match_flags_reg;
    logic [3:0]        match_flags_next;

    logic [3:0] hit;
    logic [3:0] end_hit;
    logic       is_rearm;
    logic       is_full;
    logic       is_nl;
    logic       byte_taken;

    // A word moves on whenever the output register has room.
    assign take       = item_valid && res_ready;
    assign is_rearm   = (item.kind == atrlm_pkg::KIND_REARM);
    assign is_full    = (fill_count_reg >= FILL_LIMIT);
    assign is_nl      = (item.rx_byte == atrlm_pkg::NEWLINE);
    assign byte_taken = take && !is_rearm && !is_full;

    // Compare the byte against the next character of every pattern at once.
    always_comb
    begin
        for (int i = 0; i < atrlm_pkg::PAT_COUNT; i++)
        begin
            hit[i] = match_flags_reg[i]
                     && (line_length_reg < atrlm_pkg::PAT_LEN[i])
                     && (atrlm_pkg::PAT_TEXT[i][line_length_reg] == item.rx_byte);
            end_hit[i] = hit[i]
                         && (({1'b0, line_length_reg} + 5'd1)
                             == {1'b0, atrlm_pkg::PAT_LEN[i]});
        end
    end

    // Result: the first pattern completed by a newline.
    always_comb
    begin
        res.valid = byte_taken && is_nl && (|end_hit);
        if (end_hit[0])
        begin
            res.code = atrlm_pkg::ACK_OK;
        end
        else if (end_hit[1])
        begin
            res.code = atrlm_pkg::ACK_ERROR;
        end
        else if (end_hit[2])
        begin
            res.code = atrlm_pkg::ACK_BUSY;
        end
        else
        begin
            res.code = atrlm_pkg::ACK_READY;
        end
    end

    // Next line state: rearm resets everything, a newline starts a new line; a full buffer drops bytes.
    always_comb
    begin
        fill_count_next  = fill_count_reg;
        line_length_next = line_length_reg;
        match_flags_next = match_flags_reg;
        if (take && is_rearm)
        begin
            fill_count_next  = '0;
            line_length_next = '0;
            match_flags_next = '1;
        end
        else if (byte_taken)
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
            if (is_nl)
            begin
                line_length_next = '0;
                match_flags_next = '1;
            end
            else
            begin
                match_flags_next = hit;
                if (line_length_reg < atrlm_pkg::LINE_SAT)
                begin
                    line_length_next = line_length_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg  <= '0;
            line_length_reg <= '0;
            match_flags_reg <= '1;
        end
        else
        begin
            fill_count_reg  <= fill_count_next;
            line_length_reg <= line_length_next;
            match_flags_reg <= match_flags_next;
        end
    end

    // Checks on the line state.
    `ATRLM_ASSERT_ALWAYS(a_fill_in_range, fill_count_reg <= FILL_LIMIT)
    `ATRLM_ASSERT_ALWAYS(a_single_end_hit, !byte_taken || !is_nl || $onehot0(end_hit))
    `ATRLM_ASSERT_ALWAYS(a_result_on_newline, !res.valid || (take && is_nl))
    `ATRLM_ASSERT_NEXT(a_rearm_clears, take && is_rearm,
                       fill_count_reg == '0 && line_length_reg == '0 && match_flags_reg == '1)
    `ATRLM_ASSERT_NEXT(a_newline_restarts, byte_taken && is_nl,
                       line_length_reg == '0 && match_flags_reg == '1)

endmodule

FILE: rtl/atrlm_out_stage.sv
// Output register of the AT response line matcher: holds one acknowledgement word.
// Depends on atrlm_pkg for the result type.
`timescale 1ns / 1ps

module atrlm_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  atrlm_pkg::result_t res,
    output logic               res_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         ack_code
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    atrlm_pkg::ack_code_t ack_code_reg;

    // Room for a new word when empty or when the held word leaves now.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            ack_code_reg <= res.code;
        end
    end

    assign out_valid = out_valid_reg;
    assign ack_code  = ack_code_reg;

endmodule

FILE: rtl/at_response_line_matcher_core.sv
// Top level of the AT response line matcher: input register, line match, output register.
// Depends on atrlm_pkg, atrlm_in_stage, atrlm_line_match and atrlm_out_stage.
//
//   Channel | Handshake            | Fields
//   --------+----------------------+------------------------------
//   input   | in_valid / in_ready  | kind (1b), rx_byte (8b)
//   output  | out_valid / out_ready| ack_code (2b)
//
// One word is accepted per cycle while the output has room; a line acknowledgement
// passes from the input register through the pattern compare into the output register.
// The rate is set by the combinational pattern compare and the line state update.
// Reset clears the valid bits, the fill count and the line length, and sets the match flags.
// A held output word stalls the match stage; the input register then holds one
// word and in_ready drops until the output drains.
`timescale 1ns / 1ps

module at_response_line_matcher_core #(
    parameter int BUFFER_BYTES = atrlm_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] ack_code
);

    logic               item_valid;
    atrlm_pkg::item_t   item;
    logic               take;
    logic               res_ready;
    atrlm_pkg::result_t res;

    // Input register.
    atrlm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Line state and pattern compare.
    atrlm_line_match #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_line_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .res_ready  (res_ready),
        .take       (take),
        .res        (res)
    );

    // Output register.
    atrlm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ack_code  (ack_code)
    );

endmodule

FILE: test/at_response_line_matcher_core_test.sv
// Self-checking testbench for at_response_line_matcher_core: a directed table, then random waits.
// Depends on atrlm_pkg and the core RTL; expected acknowledgements come from a predictor or typed rows.
`timescale 1ns / 1ps

module at_response_line_matcher_core_test;

    localparam int RX_BUFFER_BYTES = 1024;
    localparam int TIMEOUT_NS      = 1000000;
    localparam int QUIET_TAIL      = 150;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 16;

    localparam logic [7:0] ASCII_CR  = 8'h0D;
    localparam logic [7:0] ASCII_LF  = 8'h0A;
    localparam logic [7:0] ASCII_NUL = 8'h00;

    // Acknowledgement texts, left aligned in eleven byte slots.
    localparam int ACK_MAX = 11;
    localparam logic [8*ACK_MAX-1:0] TEXT_OK    = {"OK", ASCII_CR, ASCII_LF, 56'h0};
    localparam logic [8*ACK_MAX-1:0] TEXT_ERROR = {"ERROR", ASCII_CR, ASCII_LF, 32'h0};
    localparam logic [8*ACK_MAX-1:0] TEXT_BUSY  = {"busy p...", ASCII_CR, ASCII_LF};
    localparam logic [8*ACK_MAX-1:0] TEXT_READY = {"ready", ASCII_CR, ASCII_LF, 32'h0};

    // How the expectation of a stimulus word is formed.
    typedef enum logic [1:0] {
        EXP_MODEL = 2'd0,
        EXP_NONE  = 2'd1,
        EXP_TYPED = 2'd2
    } exp_source_t;

    typedef struct packed {
        atrlm_pkg::kind_t     kind;
        logic [7:0]           data;
        exp_source_t          source;
        atrlm_pkg::ack_code_t ack;
    } rx_item_t;

    // Directed words: acknowledgement right after reset, NUL and 0xFF bytes, empty and
    // unmatched lines, a rearm in the middle of a line.
    localparam int DIRECTED_COUNT = 22;
    localparam rx_item_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{atrlm_pkg::KIND_BYTE,  "O",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "K",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_CR,  EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_LF,  EXP_TYPED, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_NUL, EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_LF,  EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  8'hFF,     EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_LF,  EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_LF,  EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_REARM, 8'hFF,     EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "E",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "R",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "R",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "O",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "R",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_CR,  EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_LF,  EXP_TYPED, atrlm_pkg::ACK_ERROR},
        '{atrlm_pkg::KIND_BYTE,  "O",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  "K",       EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_REARM, ASCII_NUL, EXP_NONE,  atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_CR,  EXP_MODEL, atrlm_pkg::ACK_OK},
        '{atrlm_pkg::KIND_BYTE,  ASCII_LF,  EXP_NONE,  atrlm_pkg::ACK_OK}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       kind      = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] ack_code;

    rx_item_t             rx_stream [$];
    atrlm_pkg::ack_code_t pending_acks [$];
    int        accepted_words    = 0;
    int        quiet_from        = 0;
    int        bytes_since_rearm = 0;
    int        fail_count        = 0;

    // Predicted line state.
    int         fill_q     = 0;
    int         line_len   = 0;
    logic [3:0] live_flags = 4'hF;

    at_response_line_matcher_core #(
        .BUFFER_BYTES(RX_BUFFER_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ack_code  (ack_code)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Byte j of acknowledgement text p.
    function automatic logic [7:0] ack_char(input int p, input int j);
        logic [8*ACK_MAX-1:0] text;
        case (p)
            0:       text = TEXT_OK;
            1:       text = TEXT_ERROR;
            2:       text = TEXT_BUSY;
            default: text = TEXT_READY;
        endcase
        return text[8*(ACK_MAX-1-j) +: 8];
    endfunction

    function automatic int ack_len(input int p);
        case (p)
            0:       return 4;
            2:       return 11;
            default: return 7;
        endcase
    endfunction

    // Advances the predicted line state by one word; returns 1 when a line acknowledgement is due.
    function automatic bit match_line_byte(input atrlm_pkg::kind_t k, input logic [7:0] b,
                                           output atrlm_pkg::ack_code_t code);
        logic [3:0] hit;
        bit         found;
        hit   = 4'h0;
        found = 1'b0;
        code  = atrlm_pkg::ACK_OK;
        if (k == atrlm_pkg::KIND_REARM)
        begin
            fill_q     = 0;
            line_len   = 0;
            live_flags = 4'hF;
            return 1'b0;
        end
        // A full buffer drops the byte without touching the line.
        if (fill_q >= RX_BUFFER_BYTES - 1)
            return 1'b0;
        fill_q++;
        for (int p = 0; p < 4; p++)
        begin
            if (live_flags[p] && line_len < ack_len(p) && ack_char(p, line_len) == b)
                hit[p] = 1'b1;
        end
        if (b == ASCII_LF)
        begin
            for (int p = 0; p < 4; p++)
            begin
                if (!found && hit[p] && line_len + 1 == ack_len(p))
                begin
                    found = 1'b1;
                    code  = atrlm_pkg::ack_code_t'(p);
                end
            end
            line_len   = 0;
            live_flags = 4'hF;
            return found;
        end
        live_flags = hit;
        if (line_len < 15)
            line_len++;
        return 1'b0;
    endfunction

    task automatic add_word(input atrlm_pkg::kind_t k, input logic [7:0] d);
        rx_item_t w;
        w.kind   = k;
        w.data   = d;
        w.source = EXP_MODEL;
        w.ack    = atrlm_pkg::ACK_OK;
        rx_stream.push_back(w);
        if (k == atrlm_pkg::KIND_REARM)
            bytes_since_rearm = 0;
        else
            bytes_since_rearm++;
    endtask

    // One random line: mostly clean acknowledgements, the rest damaged ones and noise.
    // A line broken by a rearm is only drawn when allow_rearm is set.
    task automatic add_line(input bit allow_rearm);
        int sel;
        int p;
        int n;
        int pos;
        sel = $urandom_range(0, 19);
        p   = $urandom_range(0, 3);
        n   = ack_len(p);
        if (!allow_rearm && sel == 18)
            sel = 0;
        if (sel < 12)
        begin
            for (int j = 0; j < n; j++)
                add_word(atrlm_pkg::KIND_BYTE, ack_char(p, j));
        end
        else if (sel < 14)
        begin
            // One flipped bit somewhere in the text.
            pos = $urandom_range(0, n - 1);
            for (int j = 0; j < n; j++)
                add_word(atrlm_pkg::KIND_BYTE,
                         (j == pos) ? ack_char(p, j) ^ (8'h01 << $urandom_range(0, 7))
                                    : ack_char(p, j));
        end
        else if (sel < 15)
        begin
            // Newline without the carriage return.
            for (int j = 0; j < n - 2; j++)
                add_word(atrlm_pkg::KIND_BYTE, ack_char(p, j));
            add_word(atrlm_pkg::KIND_BYTE, ASCII_LF);
        end
        else if (sel < 16)
        begin
            // Extra byte before the carriage return.
            for (int j = 0; j < n - 2; j++)
                add_word(atrlm_pkg::KIND_BYTE, ack_char(p, j));
            add_word(atrlm_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
            add_word(atrlm_pkg::KIND_BYTE, ASCII_CR);
            add_word(atrlm_pkg::KIND_BYTE, ASCII_LF);
        end
        else if (sel < 18)
        begin
            n = $urandom_range(0, 24);
            for (int j = 0; j < n; j++)
                add_word(atrlm_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
            add_word(atrlm_pkg::KIND_BYTE, ASCII_LF);
        end
        else if (sel < 19)
        begin
            // Broken by a rearm partway through.
            pos = $urandom_range(0, n - 1);
            for (int j = 0; j < pos; j++)
                add_word(atrlm_pkg::KIND_BYTE, ack_char(p, j));
            add_word(atrlm_pkg::KIND_REARM, 8'($urandom_range(0, 255)));
        end
        else
        begin
            // Long line whose tail looks like an acknowledgement.
            pos = $urandom_range(15, 30);
            for (int j = 0; j < pos; j++)
                add_word(atrlm_pkg::KIND_BYTE, 8'($urandom_range(32, 126)));
            for (int j = 0; j < n; j++)
                add_word(atrlm_pkg::KIND_BYTE, ack_char(p, j));
        end
    endtask

    // One wait: lines until the goal of bytes since the last rearm, then a rearm.
    // A wait meant to fill the buffer keeps rearms out of its lines.
    task automatic add_wait(input int goal);
        while (bytes_since_rearm < goal)
            add_line(goal < RX_BUFFER_BYTES);
        add_word(atrlm_pkg::KIND_REARM, 8'($urandom_range(0, 255)));
    endtask

    task automatic build_stream();
        for (int i = 0; i < DIRECTED_COUNT; i++)
            rx_stream.push_back(DIRECTED_ROWS[i]);
        bytes_since_rearm = 0;
        while (rx_stream.size() < 450)
            add_wait($urandom_range(4, 80));
        // One wait long enough to fill the buffer and drop bytes.
        add_wait($urandom_range(1040, 1070));
        while (rx_stream.size() < 1560)
            add_wait($urandom_range(4, 80));
        quiet_from = rx_stream.size() - QUIET_TAIL;
    endtask

    // Sender: offers the stream in order, with idle bursts outside the quiet tail.
    initial
    begin
        int idx;
        idx = 0;
        wait (rst_n);
        @(posedge clk);
        while (idx < rx_stream.size())
        begin
            if (idx < quiet_from && (idx / 100) % 3 != 0 && $urandom_range(0, 6) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            in_valid <= 1'b1;
            kind     <= rx_stream[idx].kind;
            rx_byte  <= rx_stream[idx].data;
            do
                @(posedge clk);
            while (!in_ready);
            idx++;
        end
        in_valid <= 1'b0;
    end

    // Receiver: random stalls, and one long hold so the core backs up into its input.
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && accepted_words >= 300)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (accepted_words < quiet_from && (accepted_words / 100) % 3 != 1
                     && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Predicts on every accepted input word and checks every accepted output word.
    always @(posedge clk)
    begin : monitor
        rx_item_t             w;
        atrlm_pkg::ack_code_t code;
        atrlm_pkg::ack_code_t want;
        bit                   due;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                w   = rx_stream[accepted_words];
                due = match_line_byte(atrlm_pkg::kind_t'(kind), rx_byte, code);
                case (w.source)
                    EXP_TYPED: pending_acks.push_back(w.ack);
                    EXP_MODEL: if (due) pending_acks.push_back(code);
                    default:   ;
                endcase
                accepted_words++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_acks.size() == 0)
                begin
                    $error("ack_code: expected no word, actual %0d", ack_code);
                    fail_count++;
                end
                else
                begin
                    want = pending_acks.pop_front();
                    if (ack_code !== want)
                    begin
                        $error("ack_code: expected %0d, actual %0d", want, ack_code);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Reset, then wait for the stream to drain and give the verdict.
    initial
    begin
        build_stream();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_words < rx_stream.size() || pending_acks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_acks.size() != 0)
        begin
            $error("ack_code: %0d expected words never arrived", pending_acks.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/atrlm_pkg.sv
rtl/atrlm_in_stage.sv
rtl/atrlm_line_match.sv
rtl/atrlm_out_stage.sv
rtl/at_response_line_matcher_core.sv
test/at_response_line_matcher_core_test.sv
